// ===== rtl/btpc_pkg.sv =====
// ---------------------------------------------------------------------------
// Barometric compensation package
// Shared constants and the sideband type for the compensation pipeline.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package btpc_pkg;

   localparam int DIV_STAGES = 64;

   localparam logic [1:0] REG_TEMP_COEFFS = 2'd0;
   localparam logic [1:0] REG_PRES_LOW    = 2'd1;
   localparam logic [1:0] REG_PRES_HIGH   = 2'd2;
   localparam logic [1:0] REG_PRES_NINE   = 2'd3;

   localparam logic signed [14:0] TEMP_LOW  = -15'sd4000;
   localparam logic signed [14:0] TEMP_HIGH = 15'sd8500;
   localparam logic [24:0]        PRES_MAX  = 25'd33554431;
   localparam logic [25:0]        TFINE_BIAS = 26'd128000;
   localparam logic [63:0]        X_BIAS    = 64'h0000_8000_0000_0000;
   localparam logic [20:0]        PRES_FULL = 21'h100000;
   localparam logic [11:0]        NUM_SCALE = 12'd3125;

   typedef struct packed {
      logic [14:0] temp;
      logic        neg;
      logic        fault;
   } side_type;

endpackage

// ===== rtl/baro_temp_pressure_compensate.sv =====
// ---------------------------------------------------------------------------
// Barometric temperature and pressure compensation
// Integer compensation of raw temperature and pressure readings against
// twelve calibration coefficients, fully pipelined.
// ---------------------------------------------------------------------------
//  channel  direction  handshake                beat
//  req      in         req_tvalid/req_tready    raw_temp, raw_pres
//  rsp      out        rsp_tvalid/rsp_tready    temp_centi, pres_q24_8, div_fault
//  csr      in         APB, pready always high  four coefficient registers
//
//  One beat enters per cycle unless rsp stalls; the pipeline has 13 arithmetic
//  stages, 64 divider stages (one quotient bit each) and 8 pressure finish stages.
//  Reset clears the coefficient registers and all stage valid bits.
//  A stall at rsp holds every stage in place and drops req_tready.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module baro_temp_pressure_compensate
   import btpc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // raw_temp[19:0], raw_pres[39:20]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // temp_centi[14:0], pres_q24_8[39:15]
   output logic [0:0]  rsp_tuser,   // div_fault[0]
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [63:0] csr_pwdata,
   output logic [63:0] csr_prdata,
   output logic        csr_pready
);

   // configuration
   logic [47:0] temp_coeffs_ff;
   logic [63:0] pres_low_ff;
   logic [63:0] pres_high_ff;
   logic [15:0] pres_nine_ff;
   logic        csr_write;
   logic [1:0]  csr_index;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_index  = csr_paddr[4:3];

   always_ff @(posedge clock) begin
      if (reset) begin
         temp_coeffs_ff <= '0;
         pres_low_ff    <= '0;
         pres_high_ff   <= '0;
         pres_nine_ff   <= '0;
      end else if (csr_write) begin
         case (csr_index)
            REG_TEMP_COEFFS: temp_coeffs_ff <= csr_pwdata[47:0];
            REG_PRES_LOW:    pres_low_ff    <= csr_pwdata;
            REG_PRES_HIGH:   pres_high_ff   <= csr_pwdata;
            REG_PRES_NINE:   pres_nine_ff   <= csr_pwdata[15:0];
            default:         pres_nine_ff   <= pres_nine_ff;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_TEMP_COEFFS: csr_prdata = {16'b0, temp_coeffs_ff};
         REG_PRES_LOW:    csr_prdata = pres_low_ff;
         REG_PRES_HIGH:   csr_prdata = pres_high_ff;
         REG_PRES_NINE:   csr_prdata = {48'b0, pres_nine_ff};
         default:         csr_prdata = '0;
      endcase
   end

   logic [15:0]        t1;
   logic signed [15:0] t2, t3;
   logic [15:0]        p1;
   logic signed [15:0] p2, p3, p4, p5, p6, p7, p8, p9;

   assign t1 = temp_coeffs_ff[15:0];
   assign t2 = $signed(temp_coeffs_ff[31:16]);
   assign t3 = $signed(temp_coeffs_ff[47:32]);
   assign p1 = pres_low_ff[15:0];
   assign p2 = $signed(pres_low_ff[31:16]);
   assign p3 = $signed(pres_low_ff[47:32]);
   assign p4 = $signed(pres_low_ff[63:48]);
   assign p5 = $signed(pres_high_ff[15:0]);
   assign p6 = $signed(pres_high_ff[31:16]);
   assign p7 = $signed(pres_high_ff[47:32]);
   assign p8 = $signed(pres_high_ff[63:48]);
   assign p9 = $signed(pres_nine_ff);

   // pipeline control
   logic        advance;
   logic [12:0] pre_valid_ff;
   logic [7:0]  post_valid_ff;
   logic        div_valid;

   assign advance    = ~post_valid_ff[7] | rsp_tready;
   assign req_tready = advance;
   assign rsp_tvalid = post_valid_ff[7];

   always_ff @(posedge clock) begin
      if (reset) begin
         pre_valid_ff  <= '0;
         post_valid_ff <= '0;
      end else if (advance) begin
         pre_valid_ff  <= {pre_valid_ff[11:0], req_tvalid};
         post_valid_ff <= {post_valid_ff[6:0], div_valid};
      end
   end

   // stage registers
   logic signed [18:0] s1_dt1_ff, s1_dt1_in;
   logic signed [17:0] s1_d_ff, s1_d_in;
   logic [19:0]        s1_adcp_ff, s2_adcp_ff, s3_adcp_ff, s4_adcp_ff;
   logic [19:0]        s5_adcp_ff, s6_adcp_ff, s7_adcp_ff, s8_adcp_ff, s9_adcp_ff;
   logic signed [34:0] s2_m1_ff, s2_m1_in;
   logic [31:0]        s2_dd_ff, s2_dd_in;
   logic signed [35:0] dd_full;
   logic signed [23:0] s3_a_ff;
   logic signed [36:0] s3_m2_ff, s3_m2_in;
   logic [24:0]        s4_tf_ff, s4_tf_in;
   logic [14:0]        s5_temp_ff, s5_temp_in;
   logic signed [25:0] s5_pa_ff, s5_pa_in;
   logic [14:0]        s6_temp_ff, s7_temp_ff, s8_temp_ff, s9_temp_ff;
   logic [14:0]        s10_temp_ff, s11_temp_ff, s12_temp_ff;
   logic signed [51:0] s6_aa_ff, s6_aa_in;
   logic signed [41:0] s6_ap5_ff, s6_ap5_in, s6_ap2_ff, s6_ap2_in;
   logic signed [41:0] s7_ap5_ff, s7_ap2_ff;
   logic signed [42:0] s7_l6_ff, s7_l6_in, s7_l3_ff, s7_l3_in;
   logic signed [41:0] s7_h6_ff, s7_h6_in, s7_h3_ff, s7_h3_in;
   logic [63:0]        s8_b6_ff, s8_b6_in, s8_c3_ff, s8_c3_in;
   logic [63:0]        s8_e5_ff, s8_e5_in, s8_e2_ff, s8_e2_in;
   logic [63:0]        s9_b_ff, s9_b_in, s9_a1_ff, s9_a1_in;
   logic [63:0]        s10_x_ff, s10_x_in, s10_nb_ff, s10_nb_in;
   logic [20:0]        pr;
   logic [47:0]        s11_xl_ff, s11_xl_in;
   logic [31:0]        s11_xh_ff, s11_xh_in;
   logic [43:0]        s11_nl_ff, s11_nl_in;
   logic [31:0]        s11_nh_ff, s11_nh_in;
   logic [47:0]        xh_full;
   logic [43:0]        nh_full;
   logic [63:0]        s12_den_ff, s12_den_in, s12_num_ff, s12_num_in;
   logic [63:0]        den_full;
   logic [63:0]        s13_mn_ff, s13_mn_in, s13_md_ff, s13_md_in;
   side_type           s13_side_ff, s13_side_in;
   logic [27:0]        tv_full;
   logic signed [19:0] tv;

   always_comb begin
      s1_dt1_in = $signed({2'b0, req_tdata[19:3]}) - $signed({1'b0, t1, 1'b0});
      s1_d_in   = $signed({2'b0, req_tdata[19:4]}) - $signed({2'b0, t1});

      s2_m1_in  = s1_dt1_ff * t2;
      dd_full   = s1_d_ff * s1_d_ff;
      s2_dd_in  = dd_full[31:0];

      s3_m2_in  = $signed({1'b0, s2_dd_ff[31:12]}) * t3;

      s4_tf_in  = {s3_a_ff[23], s3_a_ff} + {{2{s3_m2_ff[36]}}, s3_m2_ff[36:14]};

      tv_full   = {{3{s4_tf_ff[24]}}, s4_tf_ff} * 28'd5 + 28'd128;
      tv        = $signed(tv_full[27:8]);
      if (tv < TEMP_LOW) begin
         s5_temp_in = TEMP_LOW;
      end else if (tv > TEMP_HIGH) begin
         s5_temp_in = TEMP_HIGH;
      end else begin
         s5_temp_in = tv[14:0];
      end
      s5_pa_in  = $signed({s4_tf_ff[24], s4_tf_ff} - TFINE_BIAS);

      s6_aa_in  = s5_pa_ff * s5_pa_ff;
      s6_ap5_in = s5_pa_ff * p5;
      s6_ap2_in = s5_pa_ff * p2;

      s7_l6_in  = $signed({1'b0, s6_aa_ff[25:0]}) * p6;
      s7_h6_in  = $signed(s6_aa_ff[51:26]) * p6;
      s7_l3_in  = $signed({1'b0, s6_aa_ff[25:0]}) * p3;
      s7_h3_in  = $signed(s6_aa_ff[51:26]) * p3;

      s8_b6_in  = {{21{s7_l6_ff[42]}}, s7_l6_ff} + {s7_h6_ff[37:0], 26'b0};
      s8_c3_in  = {{21{s7_l3_ff[42]}}, s7_l3_ff} + {s7_h3_ff[37:0], 26'b0};
      s8_e5_in  = {{5{s7_ap5_ff[41]}}, s7_ap5_ff, 17'b0};
      s8_e2_in  = {{10{s7_ap2_ff[41]}}, s7_ap2_ff, 12'b0};

      s9_b_in   = s8_b6_ff + s8_e5_ff + {{13{p4[15]}}, p4, 35'b0};
      s9_a1_in  = {{8{s8_c3_ff[63]}}, s8_c3_ff[63:8]} + s8_e2_ff;

      pr        = PRES_FULL - {1'b0, s9_adcp_ff};
      s10_x_in  = s9_a1_ff + X_BIAS;
      s10_nb_in = {12'b0, pr, 31'b0} - s9_b_ff;

      s11_xl_in = s10_x_ff[31:0] * p1;
      xh_full   = s10_x_ff[63:32] * p1;
      s11_xh_in = xh_full[31:0];
      s11_nl_in = s10_nb_ff[31:0] * NUM_SCALE;
      nh_full   = s10_nb_ff[63:32] * NUM_SCALE;
      s11_nh_in = nh_full[31:0];

      den_full   = {16'b0, s11_xl_ff} + {s11_xh_ff, 32'b0};
      s12_den_in = {{33{den_full[63]}}, den_full[63:33]};
      s12_num_in = {20'b0, s11_nl_ff} + {s11_nh_ff, 32'b0};

      s13_mn_in        = s12_num_ff[63] ? 64'(0 - s12_num_ff) : s12_num_ff;
      s13_md_in        = s12_den_ff[63] ? 64'(0 - s12_den_ff) : s12_den_ff;
      s13_side_in.temp  = s12_temp_ff;
      s13_side_in.neg   = s12_num_ff[63] ^ s12_den_ff[63];
      s13_side_in.fault = (s12_den_ff == '0);
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_dt1_ff   <= s1_dt1_in;
         s1_d_ff     <= s1_d_in;
         s1_adcp_ff  <= req_tdata[39:20];
         s2_m1_ff    <= s2_m1_in;
         s2_dd_ff    <= s2_dd_in;
         s2_adcp_ff  <= s1_adcp_ff;
         s3_a_ff     <= s2_m1_ff[34:11];
         s3_m2_ff    <= s3_m2_in;
         s3_adcp_ff  <= s2_adcp_ff;
         s4_tf_ff    <= s4_tf_in;
         s4_adcp_ff  <= s3_adcp_ff;
         s5_temp_ff  <= s5_temp_in;
         s5_pa_ff    <= s5_pa_in;
         s5_adcp_ff  <= s4_adcp_ff;
         s6_aa_ff    <= s6_aa_in;
         s6_ap5_ff   <= s6_ap5_in;
         s6_ap2_ff   <= s6_ap2_in;
         s6_temp_ff  <= s5_temp_ff;
         s6_adcp_ff  <= s5_adcp_ff;
         s7_l6_ff    <= s7_l6_in;
         s7_h6_ff    <= s7_h6_in;
         s7_l3_ff    <= s7_l3_in;
         s7_h3_ff    <= s7_h3_in;
         s7_ap5_ff   <= s6_ap5_ff;
         s7_ap2_ff   <= s6_ap2_ff;
         s7_temp_ff  <= s6_temp_ff;
         s7_adcp_ff  <= s6_adcp_ff;
         s8_b6_ff    <= s8_b6_in;
         s8_c3_ff    <= s8_c3_in;
         s8_e5_ff    <= s8_e5_in;
         s8_e2_ff    <= s8_e2_in;
         s8_temp_ff  <= s7_temp_ff;
         s8_adcp_ff  <= s7_adcp_ff;
         s9_b_ff     <= s9_b_in;
         s9_a1_ff    <= s9_a1_in;
         s9_temp_ff  <= s8_temp_ff;
         s9_adcp_ff  <= s8_adcp_ff;
         s10_x_ff    <= s10_x_in;
         s10_nb_ff   <= s10_nb_in;
         s10_temp_ff <= s9_temp_ff;
         s11_xl_ff   <= s11_xl_in;
         s11_xh_ff   <= s11_xh_in;
         s11_nl_ff   <= s11_nl_in;
         s11_nh_ff   <= s11_nh_in;
         s11_temp_ff <= s10_temp_ff;
         s12_den_ff  <= s12_den_in;
         s12_num_ff  <= s12_num_in;
         s12_temp_ff <= s11_temp_ff;
         s13_mn_ff   <= s13_mn_in;
         s13_md_ff   <= s13_md_in;
         s13_side_ff <= s13_side_in;
      end
   end

   // divider
   logic [63:0] div_q;
   side_type    div_side;

   btpc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .in_valid (pre_valid_ff[12]),
      .dividend (s13_mn_ff),
      .divisor  (s13_md_ff),
      .side_in  (s13_side_ff),
      .out_valid(div_valid),
      .quotient (div_q),
      .side_out (div_side)
   );

   // pressure finish
   logic [63:0]        q1_p_ff, q1_p_in;
   side_type           q1_side_ff, q2_side_ff, q3_side_ff, q4_side_ff;
   side_type           q5_side_ff, q6_side_ff, q7_side_ff;
   logic [63:0]        q2_p_ff, q2_s_ff, q2_s_in;
   logic signed [48:0] q2_sl9_ff, q2_sl9_in, q2_pl8_ff, q2_pl8_in;
   logic [31:0]        q2_sh9_ff, q2_sh9_in, q2_ph8_ff, q2_ph8_in;
   logic [63:0]        sh9_full, ph8_full;
   logic [63:0]        q3_p_ff, q3_u_ff, q3_u_in, q3_s_ff, q3_d8_ff, q3_d8_in;
   logic [63:0]        d8_full;
   logic [63:0]        q4_p_ff, q4_d8_ff, q4_ll_ff, q4_ll_in;
   logic [31:0]        q4_lh_ff, q4_lh_in, q4_hl_ff, q4_hl_in;
   logic [63:0]        lh_full, hl_full;
   logic [63:0]        q5_p_ff, q5_d8_ff, q5_b9_ff, q5_b9_in, v_full;
   logic [63:0]        q6_sum_ff, q6_sum_in;
   logic [63:0]        q7_r_ff, q7_r_in;
   logic [24:0]        q8_pres_ff, q8_pres_in;
   logic [14:0]        q8_temp_ff;
   logic               q8_fault_ff;

   always_comb begin
      q1_p_in   = div_side.neg ? 64'(0 - div_q) : div_q;

      q2_s_in   = {{13{q1_p_ff[63]}}, q1_p_ff[63:13]};
      q2_sl9_in = $signed({1'b0, q2_s_in[31:0]}) * p9;
      sh9_full  = q2_s_in[63:32] * {{16{p9[15]}}, p9};
      q2_sh9_in = sh9_full[31:0];
      q2_pl8_in = $signed({1'b0, q1_p_ff[31:0]}) * p8;
      ph8_full  = q1_p_ff[63:32] * {{16{p8[15]}}, p8};
      q2_ph8_in = ph8_full[31:0];

      q3_u_in   = {{15{q2_sl9_ff[48]}}, q2_sl9_ff} + {q2_sh9_ff, 32'b0};
      d8_full   = {{15{q2_pl8_ff[48]}}, q2_pl8_ff} + {q2_ph8_ff, 32'b0};
      q3_d8_in  = {{19{d8_full[63]}}, d8_full[63:19]};

      q4_ll_in  = q3_u_ff[31:0] * q3_s_ff[31:0];
      lh_full   = q3_u_ff[31:0] * q3_s_ff[63:32];
      hl_full   = q3_u_ff[63:32] * q3_s_ff[31:0];
      q4_lh_in  = lh_full[31:0];
      q4_hl_in  = hl_full[31:0];

      v_full    = q4_ll_ff + {32'(q4_lh_ff + q4_hl_ff), 32'b0};
      q5_b9_in  = {{25{v_full[63]}}, v_full[63:25]};

      q6_sum_in = q5_p_ff + q5_b9_ff + q5_d8_ff;

      q7_r_in   = {{8{q6_sum_ff[63]}}, q6_sum_ff[63:8]} + {{44{p7[15]}}, p7, 4'b0};

      if (q7_side_ff.fault || q7_r_ff[63]) begin
         q8_pres_in = '0;
      end else if (q7_r_ff[62:25] != '0) begin
         q8_pres_in = PRES_MAX;
      end else begin
         q8_pres_in = q7_r_ff[24:0];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         q1_p_ff     <= q1_p_in;
         q1_side_ff  <= div_side;
         q2_p_ff     <= q1_p_ff;
         q2_s_ff     <= q2_s_in;
         q2_sl9_ff   <= q2_sl9_in;
         q2_sh9_ff   <= q2_sh9_in;
         q2_pl8_ff   <= q2_pl8_in;
         q2_ph8_ff   <= q2_ph8_in;
         q2_side_ff  <= q1_side_ff;
         q3_p_ff     <= q2_p_ff;
         q3_u_ff     <= q3_u_in;
         q3_s_ff     <= q2_s_ff;
         q3_d8_ff    <= q3_d8_in;
         q3_side_ff  <= q2_side_ff;
         q4_p_ff     <= q3_p_ff;
         q4_d8_ff    <= q3_d8_ff;
         q4_ll_ff    <= q4_ll_in;
         q4_lh_ff    <= q4_lh_in;
         q4_hl_ff    <= q4_hl_in;
         q4_side_ff  <= q3_side_ff;
         q5_p_ff     <= q4_p_ff;
         q5_d8_ff    <= q4_d8_ff;
         q5_b9_ff    <= q5_b9_in;
         q5_side_ff  <= q4_side_ff;
         q6_sum_ff   <= q6_sum_in;
         q6_side_ff  <= q5_side_ff;
         q7_r_ff     <= q7_r_in;
         q7_side_ff  <= q6_side_ff;
         q8_pres_ff  <= q8_pres_in;
         q8_temp_ff  <= q7_side_ff.temp;
         q8_fault_ff <= q7_side_ff.fault;
      end
   end

   assign rsp_tdata = {q8_pres_ff, q8_temp_ff};
   assign rsp_tuser = q8_fault_ff;

endmodule

// ===== rtl/btpc_div.sv =====
// ---------------------------------------------------------------------------
// Pipelined unsigned divider
// Restoring 64-bit by 64-bit division, one quotient bit per stage.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module btpc_div
   import btpc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        advance,
   input  logic        in_valid,
   input  logic [63:0] dividend,
   input  logic [63:0] divisor,
   input  side_type    side_in,
   output logic        out_valid,
   output logic [63:0] quotient,
   output side_type    side_out
);

   logic [DIV_STAGES-1:0] valid_ff;
   logic [DIV_STAGES-1:0] valid_in;
   logic [63:0]           rem_ff  [DIV_STAGES];
   logic [63:0]           rem_in  [DIV_STAGES];
   logic [63:0]           nq_ff   [DIV_STAGES];
   logic [63:0]           nq_in   [DIV_STAGES];
   logic [63:0]           md_ff   [DIV_STAGES];
   logic [63:0]           md_in   [DIV_STAGES];
   side_type              side_ff [DIV_STAGES];
   side_type              side_in_s [DIV_STAGES];

   for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
      logic [63:0] rem_src;
      logic [63:0] nq_src;
      logic [63:0] md_src;
      side_type    side_src;
      logic        valid_src;
      logic [64:0] trial;
      logic [64:0] diff;

      if (k == 0) begin : g_first
         assign rem_src   = '0;
         assign nq_src    = dividend;
         assign md_src    = divisor;
         assign side_src  = side_in;
         assign valid_src = in_valid;
      end else begin : g_next
         assign rem_src   = rem_ff[k-1];
         assign nq_src    = nq_ff[k-1];
         assign md_src    = md_ff[k-1];
         assign side_src  = side_ff[k-1];
         assign valid_src = valid_ff[k-1];
      end

      always_comb begin
         trial        = {rem_src, nq_src[63]};
         diff         = trial - {1'b0, md_src};
         rem_in[k]    = diff[64] ? trial[63:0] : diff[63:0];
         nq_in[k]     = {nq_src[62:0], ~diff[64]};
         md_in[k]     = md_src;
         side_in_s[k] = side_src;
         valid_in[k]  = valid_src;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int k = 0; k < DIV_STAGES; k++) begin
            rem_ff[k]  <= rem_in[k];
            nq_ff[k]   <= nq_in[k];
            md_ff[k]   <= md_in[k];
            side_ff[k] <= side_in_s[k];
         end
      end
   end

   assign out_valid = valid_ff[DIV_STAGES-1];
   assign quotient  = nq_ff[DIV_STAGES-1];
   assign side_out  = side_ff[DIV_STAGES-1];

endmodule

// ===== tb/testbench.sv =====
// ---------------------------------------------------------------------------
// Barometric compensation testbench
// Drives raw temperature/pressure beats through the compensation pipeline
// under several coefficient sets and flow-control patterns. An in-bench
// integer predictor supplies the expected temperature, pressure and
// divide-fault flag for each beat, and every result beat is compared in order.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
   import btpc_pkg::*;

   typedef struct {
      logic [14:0] temp_centi;
      logic [24:0] pres_q24_8;
      logic        div_fault;
   } reading_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;    // raw_temp[19:0], raw_pres[39:20]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b1;
   logic [39:0] rsp_tdata;         // temp_centi[14:0], pres_q24_8[39:15]
   logic [0:0]  rsp_tuser;         // div_fault[0]
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [4:0]  csr_paddr = '0;
   logic [63:0] csr_pwdata = '0;
   logic [63:0] csr_prdata;
   logic        csr_pready;

   logic [47:0] temp_coeffs;
   logic [63:0] pres_low;
   logic [63:0] pres_high;
   logic [15:0] pres_nine;

   reading_type expected_q[$];
   int          mismatches = 0;
   int          send_idle_pct = 0;
   int          rsp_stall_pct = 0;

   baro_temp_pressure_compensate dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #20_000_000;
      $display("end of test: mismatches");
      $finish;
   end

   always @(posedge clock) begin
      rsp_tready <= (rsp_stall_pct == 0) || ($urandom_range(99) >= rsp_stall_pct);
   end

   function automatic longint quotient(input longint n, input longint d);
      longint unsigned mn, md, q;
      mn = (n < 0) ? 64'd0 - n : n;
      md = (d < 0) ? 64'd0 - d : d;
      q  = mn / md;
      return ((n < 0) != (d < 0)) ? longint'(64'd0 - q) : longint'(q);
   endfunction

   function automatic reading_type compensate(input logic [19:0] raw_t, input logic [19:0] raw_p);
      reading_type r;
      longint t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
      longint a, b, d, t_fine, tv, p;
      t1 = longint'(temp_coeffs[15:0]);
      t2 = longint'($signed(temp_coeffs[31:16]));
      t3 = longint'($signed(temp_coeffs[47:32]));
      p1 = longint'(pres_low[15:0]);
      p2 = longint'($signed(pres_low[31:16]));
      p3 = longint'($signed(pres_low[47:32]));
      p4 = longint'($signed(pres_low[63:48]));
      p5 = longint'($signed(pres_high[15:0]));
      p6 = longint'($signed(pres_high[31:16]));
      p7 = longint'($signed(pres_high[47:32]));
      p8 = longint'($signed(pres_high[63:48]));
      p9 = longint'($signed(pres_nine));
      a = ((longint'(raw_t >> 3) - (t1 <<< 1)) * t2) >>> 11;
      d = longint'(raw_t >> 4) - t1;
      b = (((d * d) >>> 12) * t3) >>> 14;
      t_fine = a + b;
      tv = (t_fine * 5 + 128) >>> 8;
      if (tv < -4000) tv = -4000;
      if (tv > 8500) tv = 8500;
      r.temp_centi = tv[14:0];
      r.pres_q24_8 = '0;
      r.div_fault  = 1'b0;
      a = t_fine - 128000;
      b = a * a * p6;
      b = b + ((a * p5) <<< 17);
      b = b + (p4 <<< 35);
      a = ((a * a * p3) >>> 8) + ((a * p2) <<< 12);
      a = (((longint'(1) <<< 47) + a) * p1) >>> 33;
      if (a == 0) begin
         r.div_fault = 1'b1;
      end else begin
         p = 1048576 - longint'(raw_p);
         p = quotient(((p <<< 31) - b) * 3125, a);
         b = (p9 * (p >>> 13) * (p >>> 13)) >>> 25;
         d = (p8 * p) >>> 19;
         p = ((p + b + d) >>> 8) + (p7 <<< 4);
         if (p < 0) p = 0;
         if (p > 33554431) p = 33554431;
         r.pres_q24_8 = p[24:0];
      end
      return r;
   endfunction

   always @(posedge clock) begin
      reading_type e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result beat: %h / %b", rsp_tdata, rsp_tuser);
         end else begin
            e = expected_q.pop_front();
            if (rsp_tdata[14:0] !== e.temp_centi || rsp_tdata[39:15] !== e.pres_q24_8
                  || rsp_tuser[0] !== e.div_fault) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: exp temp %0d pres %0d fault %0b, got temp %0d pres %0d fault %0b",
                     $signed(e.temp_centi), e.pres_q24_8, e.div_fault,
                     $signed(rsp_tdata[14:0]), rsp_tdata[39:15], rsp_tuser[0]);
            end
         end
      end
   end

   task automatic csr_write(input logic [1:0] index, input logic [63:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {index, 3'b000};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      case (index)
         REG_TEMP_COEFFS: temp_coeffs = value[47:0];
         REG_PRES_LOW:    pres_low    = value;
         REG_PRES_HIGH:   pres_high   = value;
         default:         pres_nine   = value[15:0];
      endcase
      @(posedge clock);
   endtask

   task automatic load_coeffs(input logic [47:0] tc, input logic [63:0] lo,
                              input logic [63:0] hi, input logic [15:0] nine);
      csr_write(REG_TEMP_COEFFS, {16'h0, tc});
      csr_write(REG_PRES_LOW, lo);
      csr_write(REG_PRES_HIGH, hi);
      csr_write(REG_PRES_NINE, {48'h0, nine});
      @(posedge clock);
   endtask

   // typical calibration set, optionally jittered
   task automatic load_typical(input int jitter);
      logic [15:0] c[12];
      int base[12] = '{27504, 26435, -1000, 36477, -10685, 3024, 2855, 140, -7,
                       15500, -14600, 6000};
      for (int i = 0; i < 12; i++)
         c[i] = 16'(base[i] + int'($urandom_range(2 * jitter)) - jitter);
      load_coeffs({c[2], c[1], c[0]}, {c[6], c[5], c[4], c[3]},
                  {c[10], c[9], c[8], c[7]}, c[11]);
   endtask

   task automatic send_reading(input logic [19:0] raw_t, input logic [19:0] raw_p);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {raw_p, raw_t};
      do @(negedge clock); while (!req_tready);
      @(posedge clock);
      expected_q.push_back(compensate(raw_t, raw_p));
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   task automatic test_reset_values();
      send_reading(20'd519888, 20'd415148);
      send_reading(20'hFFFFF, 20'h00000);
      drain();
   endtask

   task automatic test_directed();
      logic [19:0] corners[4] = '{20'h00000, 20'hFFFFF, 20'h80000, 20'h7FFFF};
      load_typical(0);
      foreach (corners[i])
         foreach (corners[j])
            send_reading(corners[i], corners[j]);
      send_reading(20'd519888, 20'd415148);
      drain();
      load_coeffs(48'h8000_8000_FFFF, 64'h8000_8000_8000_FFFF, 64'h8000_8000_8000_8000,
                  16'h8000);
      send_reading(20'h00000, 20'hFFFFF);
      send_reading(20'hFFFFF, 20'h00000);
      drain();
      load_coeffs(48'h7FFF_7FFF_0000, 64'h7FFF_7FFF_7FFF_0001, 64'h7FFF_7FFF_7FFF_7FFF,
                  16'h7FFF);
      send_reading(20'h00000, 20'h00000);
      send_reading(20'hFFFFF, 20'hFFFFF);
      drain();
      load_coeffs({16'hFC18, 16'd26435, 16'd27504}, 64'h0B27_0BD0_D641_0000, '1, '1);
      send_reading(20'd519888, 20'd415148);
      drain();
   endtask

   task automatic test_random(input int count, input int idle_pct, input int stall_pct);
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(3) == 0)
            send_reading(20'($urandom), 20'($urandom));
         else
            send_reading(20'($urandom_range(600000, 400000)),
                         20'($urandom_range(600000, 200000)));
      end
      drain();
      send_idle_pct = 0;
      rsp_stall_pct = 0;
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      temp_coeffs = '0;
      pres_low    = '0;
      pres_high   = '0;
      pres_nine   = '0;
      @(posedge clock);
      test_reset_values();
      test_directed();
      load_typical(0);
      test_random(180, 0, 0);
      load_typical(200);
      test_random(180, 67, 0);
      load_coeffs(48'($urandom) | (48'($urandom) << 32), {$urandom, $urandom},
                  {$urandom, $urandom}, 16'($urandom));
      test_random(40, 0, 67);
      load_typical(2000);
      test_random(140, 0, 67);
      load_typical(50);
      test_random(180, 31, 31);
      if (expected_q.size() != 0) mismatches++;
      if (mismatches == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/btpc_pkg.sv
rtl/btpc_div.sv
rtl/baro_temp_pressure_compensate.sv
tb/testbench.sv
